// File: rtl/bgnc_pkg.sv
// Shared types, constants and helpers of the binary grid neighbor count block.
package bgnc_pkg;

	// Configuration register indexes
	localparam logic CFG_GRID_ROWS = 1'b0;
	localparam logic CFG_GRID_COLS = 1'b1;

	// Window masks: bit 3*k+j is row j (0 = two above) of the k-th newest column
	localparam logic [8:0] WIN_FULL     = 9'h1FF;
	localparam logic [8:0] WIN_LEFT_TWO = 9'h03F;
	localparam logic [8:0] WIN_LOW_TWO  = 9'h1B6;
	localparam logic [8:0] WIN_CORNER   = 9'h036;

	// Result slots released by one cell, in raster order of their cells
	localparam logic [1:0] RES_UP_LEFT = 2'd0;
	localparam logic [1:0] RES_UP      = 2'd1;
	localparam logic [1:0] RES_LEFT    = 2'd2;
	localparam logic [1:0] RES_SELF    = 2'd3;

	// Work handed from the line-store stage to the result stage
	typedef struct packed {
		logic [8:0] window;
		logic [9:0] row;
		logic [9:0] col;
		logic [3:0] sel;
	} bgnc_load_t;

	function automatic logic [3:0] bgnc_popcount(input logic [8:0] v);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 9; i++) begin
			n = n + 4'(v[i]);
		end
		return n;
	endfunction

endpackage

// File: rtl/bgnc_line_store.sv
// Line store: two previous rows, one 2-bit entry per column, registered read.
module bgnc_line_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [1:0]    rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [1:0]    wr_data
);

	// Entry: bit 1 row two above, bit 0 row one above
	logic [1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port, old data on a same-cycle write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/bgnc_result_stage.sv
// Result stage: holds the counts one cell releases and sends them one beat at a time.
module bgnc_result_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  bgnc_pkg::bgnc_load_t load_data,
	output logic               free,
	output logic               tvalid,
	input  logic               tready,
	output logic [23:0]        tdata,  // cell_row [9:0], cell_col [19:10], window_count [23:20]
	output logic               tlast   // frame_last
);
	import bgnc_pkg::*;

	logic [3:0] pend_q;
	logic [9:0] row_q;
	logic [9:0] col_q;
	logic [3:0] cnt_q [4];
	logic [1:0] pick;
	logic       beat;
	logic [9:0] out_row;
	logic [9:0] out_col;

	// Pick the oldest pending result
	always_comb begin
		if (pend_q[0]) begin
			pick = RES_UP_LEFT;
		end else if (pend_q[1]) begin
			pick = RES_UP;
		end else if (pend_q[2]) begin
			pick = RES_LEFT;
		end else begin
			pick = RES_SELF;
		end
	end

	assign beat   = tvalid && tready;
	assign tvalid = |pend_q;
	assign free   = (pend_q == 4'b0000) || ($onehot(pend_q) && tready);

	// Row above for the first two slots, left column for the even slots
	assign out_row = (pick == RES_UP_LEFT || pick == RES_UP) ? row_q - 10'd1 : row_q;
	assign out_col = (pick == RES_UP_LEFT || pick == RES_LEFT) ? col_q - 10'd1 : col_q;
	assign tdata   = {cnt_q[pick], out_col, out_row};
	assign tlast   = (pick == RES_SELF);

	// Pending flags: load a new set, drop each slot as it is sent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (load) begin
			pend_q <= load_data.sel;
		end else if (beat) begin
			pend_q[pick] <= 1'b0;
		end
	end

	// Counts of the clipped windows, worked out once per cell
	always_ff @(posedge clk) begin
		if (load) begin
			row_q    <= load_data.row;
			col_q    <= load_data.col;
			cnt_q[0] <= bgnc_popcount(load_data.window & WIN_FULL);
			cnt_q[1] <= bgnc_popcount(load_data.window & WIN_LEFT_TWO);
			cnt_q[2] <= bgnc_popcount(load_data.window & WIN_LOW_TWO);
			cnt_q[3] <= bgnc_popcount(load_data.window & WIN_CORNER);
		end
	end

`ifndef NO_ASSERTIONS
	// A new set never overwrites results still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (pend_q == 4'b0000) || ($onehot(pend_q) && beat))
		else $error("result set loaded over pending results");

	// The frame's final beat is always the last of its set
	assert property (@(posedge clk) disable iff (!arst_n)
		tvalid && tlast |-> pend_q == 4'b1000)
		else $error("frame end sent ahead of other results");
`endif

endmodule

// File: rtl/binary_grid_neighbour_count.sv
// Binary grid neighbor count: one cell per cycle in raster order, and for each cell the
// number of set cells in its edge-clipped 3x3 window, tagged with row and column. The
// input stalls while results wait on the output; a cell that releases several results
// (the last column and the last row) holds the input until all but its last result are
// sent, since the result stage has a single output beat per cycle. The line store is read
// when a cell is taken and written back when the cell leaves stage one; its results are
// then registered in the result stage. The line store needs no clearing after reset.
module binary_grid_neighbour_count #(
	parameter int MAX_COLS = 1024,
	parameter int MAX_ROWS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // cell_set [0], zeros [7:1]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // cell_row [9:0], cell_col [19:10], window_count [23:20]
	output logic        m_axis_tlast,   // frame_last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data
);
	import bgnc_pkg::*;

	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	logic [10:0]   grid_rows_q;
	logic [10:0]   grid_cols_q;
	logic [RW:0]   rows_eff;
	logic [CW:0]   cols_eff;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic          last_row;
	logic          last_col;
	logic          s_accept;

	logic          s1_valid_q;
	logic          bit_s1;
	logic [CW-1:0] addr_s1;
	logic [9:0]    row_s1;
	logic [9:0]    col_s1;
	logic          rge1_s1;
	logic          rge2_s1;
	logic          c0_s1;
	logic          lr_s1;
	logic          lc_s1;
	logic          fwd_s1;
	logic [1:0]    fwd_data_s1;
	logic          s1_fire;

	logic [1:0]    rd_data;
	logic [1:0]    entry;
	logic [1:0]    wr_data;
	logic [2:0]    col3;
	logic [8:0]    window_q;
	logic [8:0]    window_next;
	logic          res_free;
	bgnc_load_t    load_data;

	// Configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= 11'd1024;
			grid_cols_q <= 11'd1024;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_GRID_ROWS: grid_rows_q <= cfg_data;
				CFG_GRID_COLS: grid_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp grid size to 1..MAX
	always_comb begin
		if (grid_rows_q == 11'd0) begin
			rows_eff = (RW+1)'(1);
		end else if (32'(grid_rows_q) > MAX_ROWS) begin
			rows_eff = (RW+1)'(MAX_ROWS);
		end else begin
			rows_eff = (RW+1)'(grid_rows_q);
		end
		if (grid_cols_q == 11'd0) begin
			cols_eff = (CW+1)'(1);
		end else if (32'(grid_cols_q) > MAX_COLS) begin
			cols_eff = (CW+1)'(MAX_COLS);
		end else begin
			cols_eff = (CW+1)'(grid_cols_q);
		end
	end

	assign last_row = ({1'b0, row_q} + (RW+1)'(1)) >= rows_eff;
	assign last_col = ({1'b0, col_q} + (CW+1)'(1)) >= cols_eff;

	// Take a cell when stage one is empty or moving on
	assign s1_fire       = s1_valid_q && res_free;
	assign s_axis_tready = !s1_valid_q || s1_fire;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	// Raster position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (s_accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Stage one control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			fwd_s1     <= 1'b0;
		end else if (s_accept) begin
			s1_valid_q <= 1'b1;
			fwd_s1     <= s1_fire && (addr_s1 == col_q);
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
			fwd_s1     <= 1'b0;
		end
	end

	// Stage one payload
	always_ff @(posedge clk) begin
		if (s_accept) begin
			bit_s1      <= s_axis_tdata[0];
			addr_s1     <= col_q;
			row_s1      <= 10'(row_q);
			col_s1      <= 10'(col_q);
			rge1_s1     <= (row_q != '0);
			rge2_s1     <= (row_q > RW'(1)) && (RW > 1 || row_q != '0);
			c0_s1       <= (col_q == '0);
			lr_s1       <= last_row;
			lc_s1       <= last_col;
			fwd_data_s1 <= wr_data;
		end
	end

	// Bypass a write to the same column made as this cell was read
	assign entry   = fwd_s1 ? fwd_data_s1 : rd_data;
	assign wr_data = {entry[0], bit_s1};

	bgnc_line_store #(
		.DEPTH (MAX_COLS),
		.AW    (CW)
	) u_line_store (
		.clk     (clk),
		.rd_en   (s_accept),
		.rd_addr (col_q),
		.rd_data (rd_data),
		.wr_en   (s1_fire),
		.wr_addr (addr_s1),
		.wr_data (wr_data)
	);

	// Shift the new column into the window; rows above the grid read as zero
	assign col3        = {bit_s1, entry[0] & rge1_s1, entry[1] & rge2_s1};
	assign window_next = c0_s1 ? {6'd0, col3} : {window_q[5:0], col3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (s1_fire) begin
			window_q <= window_next;
		end
	end

	// Results this cell releases
	always_comb begin
		load_data.window       = window_next;
		load_data.row          = row_s1;
		load_data.col          = col_s1;
		load_data.sel[RES_UP_LEFT] = rge1_s1 && !c0_s1;
		load_data.sel[RES_UP]      = rge1_s1 && lc_s1;
		load_data.sel[RES_LEFT]    = lr_s1 && !c0_s1;
		load_data.sel[RES_SELF]    = lr_s1 && lc_s1;
	end

	bgnc_result_stage u_result_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (s1_fire),
		.load_data (load_data),
		.free      (res_free),
		.tvalid    (m_axis_tvalid),
		.tready    (m_axis_tready),
		.tdata     (m_axis_tdata),
		.tlast     (m_axis_tlast)
	);

`ifndef NO_ASSERTIONS
	// Stage one only waits behind results still going out
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_fire |-> m_axis_tvalid)
		else $error("stage one stalled with no result pending");

	// A bypass only serves a cell that is in stage one
	assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> s1_valid_q)
		else $error("bypass flag set with stage one empty");

	// A taken cell always lands in stage one
	assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> s1_valid_q)
		else $error("accepted cell lost before stage one");

	// Columns wrap only at the last column
	assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && !last_col |=> col_q == $past(col_q) + CW'(1))
		else $error("column counter skipped");
`endif

endmodule
